// ===== design/lru_multi_size_miss_counter_core_assert.svh =====
// assertion macros used by the miss counter checker
`ifndef LRU_MULTI_SIZE_MISS_COUNTER_CORE_ASSERT_SVH
`define LRU_MULTI_SIZE_MISS_COUNTER_CORE_ASSERT_SVH

// consequent in the cycle after the antecedent
`define LMSMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lmsmc check failed");

// consequent in the same cycle as the antecedent
`define LMSMC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lmsmc check failed");

`endif

// ===== design/lmsmc_pkg.sv =====
// shared types and constants of the lru stack distance miss counter
`timescale 1ns / 1ps
`default_nettype none

package lmsmc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int NUM_SIZES   = 4;
  localparam int ADDR_BITS   = 24;
  localparam int SIZE_W      = 7;
  localparam int IN_USE_W    = 3;
  localparam int COUNT_W     = 32;
  localparam int IDX_W       = 2;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W       = (SIZE_W > DEPTH_W) ? SIZE_W : DEPTH_W;
  localparam int CNT_W       = $clog2(NUM_SIZES + 1);
  localparam int APB_ADDR_W  = 5;
  localparam int APB_DATA_W  = 32;
  localparam int REG_IDX_W   = 3;

  typedef enum logic {
    OP_ACCESS = 1'b0,
    OP_REPORT = 1'b1
  } op_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SIZE_0 = 3'd0,
    REG_SIZE_1 = 3'd1,
    REG_SIZE_2 = 3'd2,
    REG_SIZE_3 = 3'd3,
    REG_IN_USE = 3'd4
  } reg_idx_t;

  // work item travelling down the cell row
  typedef struct packed {
    logic                 valid;
    op_t                  op;
    logic [ADDR_BITS-1:0] search;
    logic [ADDR_BITS-1:0] carry;
    logic                 searching;
    logic                 found;
    logic [DEPTH_W-1:0]   depth;
  } token_t;

  // configuration seen by the counter bank
  typedef struct packed {
    logic [NUM_SIZES-1:0][SIZE_W-1:0] size;
    logic [CNT_W-1:0]                 active;
  } cfg_t;

  function automatic logic [SIZE_W-1:0] size_reset(input int i);
    logic [SIZE_W-1:0] r;
    case (i)
      0:       r = SIZE_W'(1);
      1:       r = SIZE_W'(4);
      2:       r = SIZE_W'(16);
      default: r = SIZE_W'(64);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/lmsmc_cell.sv =====
// one lru stack cell: holds one entry and passes the token on
`timescale 1ns / 1ps
`default_nettype none

module lmsmc_cell
  import lmsmc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   advance,
  input  wire token_t tok_in,
  output token_t      tok_out
);

  logic [ADDR_BITS-1:0] entry;
  logic [ADDR_BITS-1:0] entry_next;
  logic                 entry_valid;
  logic                 entry_valid_next;
  token_t               tok_next;

  always_comb begin
    tok_next         = tok_in;
    entry_next       = entry;
    entry_valid_next = entry_valid;
    if (tok_in.valid && tok_in.op == OP_ACCESS && tok_in.searching) begin
      entry_next     = tok_in.carry;
      tok_next.depth = DEPTH_W'(tok_in.depth + 1'b1);
      if (entry_valid && entry == tok_in.search) begin
        // hit: the moved entries stop here
        tok_next.found     = 1'b1;
        tok_next.searching = 1'b0;
      end else if (!entry_valid) begin
        // first empty slot: stack grows by one
        entry_valid_next   = 1'b1;
        tok_next.searching = 1'b0;
      end else begin
        tok_next.carry = entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid   <= 1'b0;
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      entry_valid <= entry_valid_next;
      tok_out     <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      entry <= entry_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/lmsmc_cfg.sv =====
// apb register file for cache sizes and sizes in use
`timescale 1ns / 1ps
`default_nettype none

module lmsmc_cfg
  import lmsmc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  logic [NUM_SIZES-1:0][SIZE_W-1:0] size;
  logic [IN_USE_W-1:0]              in_use;
  reg_idx_t                         reg_idx;
  logic                             wr_en;

  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SIZES; i++) begin
        size[i] <= size_reset(i);
      end
      in_use <= IN_USE_W'(4);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SIZE_0: size[0] <= pwdata[SIZE_W-1:0];
        REG_SIZE_1: size[1] <= pwdata[SIZE_W-1:0];
        REG_SIZE_2: size[2] <= pwdata[SIZE_W-1:0];
        REG_SIZE_3: size[3] <= pwdata[SIZE_W-1:0];
        REG_IN_USE: in_use  <= pwdata[IN_USE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SIZE_0: prdata = APB_DATA_W'(size[0]);
      REG_SIZE_1: prdata = APB_DATA_W'(size[1]);
      REG_SIZE_2: prdata = APB_DATA_W'(size[2]);
      REG_SIZE_3: prdata = APB_DATA_W'(size[3]);
      REG_IN_USE: prdata = APB_DATA_W'(in_use);
      default:    prdata = '0;
    endcase
  end

  // zero counts as one, anything above the size count is clamped
  always_comb begin
    cfg.size = size;
    if (in_use == '0) begin
      cfg.active = CNT_W'(1);
    end else if (in_use > IN_USE_W'(NUM_SIZES)) begin
      cfg.active = CNT_W'(NUM_SIZES);
    end else begin
      cfg.active = CNT_W'(in_use);
    end
  end

endmodule

`default_nettype wire

// ===== design/lmsmc_counters.sv =====
// miss counters, report snapshot and result stream
`timescale 1ns / 1ps
`default_nettype none

module lmsmc_counters
  import lmsmc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire cfg_t         cfg,
  input  wire token_t       exit_tok,
  output logic              exit_ready,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [COUNT_W-1:0] m_axis_tdata,
  output logic [IDX_W-1:0]  m_axis_tuser,
  output logic              m_axis_tlast
);

  logic [COUNT_W-1:0] counters [NUM_SIZES];
  logic [COUNT_W-1:0] snap     [NUM_SIZES];
  logic               busy;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   last_idx;
  logic               on_last;
  logic               report_free;
  logic               is_report;
  logic               take_report;
  logic               take_access;
  logic [NUM_SIZES-1:0] miss;

  assign on_last     = (idx == last_idx);
  assign report_free = !busy || (m_axis_tready && on_last);
  assign is_report   = exit_tok.valid && exit_tok.op == OP_REPORT;
  assign take_report = is_report && report_free;
  assign take_access = exit_tok.valid && exit_tok.op == OP_ACCESS;
  assign exit_ready  = !(is_report && !report_free);

  always_comb begin
    for (int i = 0; i < NUM_SIZES; i++) begin
      miss[i] = (CNT_W'(i) < cfg.active) &&
                (!exit_tok.found ||
                 CMP_W'(cfg.size[i]) < CMP_W'(exit_tok.depth));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SIZES; i++) begin
        counters[i] <= '0;
      end
    end else if (take_report) begin
      for (int i = 0; i < NUM_SIZES; i++) begin
        counters[i] <= '0;
      end
    end else if (take_access) begin
      for (int i = 0; i < NUM_SIZES; i++) begin
        if (miss[i] && counters[i] != '1) begin
          counters[i] <= counters[i] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (take_report) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && m_axis_tready) begin
      if (on_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_report) begin
      snap     <= counters;
      last_idx <= IDX_W'(cfg.active - 1'b1);
    end
  end

  assign m_axis_tvalid = busy;
  assign m_axis_tdata  = snap[idx];
  assign m_axis_tuser  = idx;
  assign m_axis_tlast  = on_last;

endmodule

`default_nettype wire

// ===== design/lru_multi_size_miss_counter_core.sv =====
// top level of the lru stack distance miss counter
//
//  channel   dir  handshake                 payload
//  s_axis    in   tvalid / tready           tdata = block_address, tuser = operation
//  m_axis    out  tvalid / tready           tdata = miss_count, tuser = size_index, tlast
//  apb       in   psel / penable / pready   paddr, pwdata, prdata (5 registers at 4*i)
//
//  an item is taken in every cycle while no report stalls the row; each item walks
//  the 64 cells of the stack row one cell a cycle, so its effect on the counters
//  lands once it has left the last cell
//  a report gives one beat per size in use; a second report reaching the row end
//  while beats still drain stalls the whole row, and s_axis_tready with it
//  reset is synchronous; the stack empties through per-cell
//  valid bits, with no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module lru_multi_size_miss_counter_core
  import lmsmc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // slave beat: tdata [23:0] block_address; tuser [0] operation
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [ADDR_BITS-1:0]  s_axis_tdata,
  input  wire logic [0:0]            s_axis_tuser,
  // master beat: tdata [31:0] miss_count; tuser [1:0] size_index
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [COUNT_W-1:0]         m_axis_tdata,
  output logic [IDX_W-1:0]           m_axis_tuser,
  output logic                       m_axis_tlast,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t   cfg;
  token_t tok [STACK_DEPTH+1];
  logic   advance;

  // the whole row moves together; it only halts for a report held at the end
  assign s_axis_tready = advance;

  // token entering the top cell: the new address is also the first carried entry
  always_comb begin
    tok[0].valid     = s_axis_tvalid;
    tok[0].op        = op_t'(s_axis_tuser[0]);
    tok[0].search    = s_axis_tdata;
    tok[0].carry     = s_axis_tdata;
    tok[0].searching = (op_t'(s_axis_tuser[0]) == OP_ACCESS);
    tok[0].found     = 1'b0;
    tok[0].depth     = '0;
  end

  lmsmc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // cell 0 is the top of the stack; a token that is still searching after the
  // last cell is a miss whose displaced bottom entry is dropped
  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    lmsmc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  lmsmc_counters u_counters (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .exit_tok      (tok[STACK_DEPTH]),
    .exit_ready    (advance),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== design/lmsmc_checker.sv =====
// port level checks on the result stream, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "lru_multi_size_miss_counter_core_assert.svh"

module lmsmc_checker
  import lmsmc_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               m_axis_tvalid,
  input wire logic               m_axis_tready,
  input wire logic [COUNT_W-1:0] m_axis_tdata,
  input wire logic [IDX_W-1:0]   m_axis_tuser,
  input wire logic               m_axis_tlast
);

  // a report always starts with the first size
  `LMSMC_ASSERT_NOW(a_first_index, !rst && $rose(m_axis_tvalid), m_axis_tuser == '0)

  // beats of one report follow without gaps, size index counting up
  `LMSMC_ASSERT_NEXT(a_index_steps, !rst && m_axis_tvalid && m_axis_tready && !m_axis_tlast,
    m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 2'd1)

  // a beat right after a taken last beat starts a new report at size index zero
  `LMSMC_ASSERT_NEXT(a_restart, !rst && m_axis_tvalid && m_axis_tready && m_axis_tlast,
    !m_axis_tvalid || m_axis_tuser == '0)

  // a stalled beat holds
  `LMSMC_ASSERT_NEXT(a_hold, !rst && m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

endmodule

bind lru_multi_size_miss_counter_core lmsmc_checker u_lmsmc_checker (.*);

`default_nettype wire
